@@ hdl/bounded_stack_with_search_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the bounded stack with search
// Shared property wrappers used by the checker.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_STACK_WITH_SEARCH_UNIT_DEFINES_SVH
`define BOUNDED_STACK_WITH_SEARCH_UNIT_DEFINES_SVH

// Clocked assertion, masked while reset is asserted.
`define BSS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define BSS_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/bss_pkg.sv @@
// ----------------------------------------------------------------------------
// bss_pkg
// Types and constants shared by the stack-with-search block.
// ----------------------------------------------------------------------------
package bss_pkg;

	localparam int WORD_W      = 32;
	localparam int POS_W       = 5;
	localparam int MAX_ITEMS   = 16;
	localparam int KW          = 4;   // display beat counter, 0..MAX_ITEMS-1
	localparam int IN_TDATA_W  = 64;  // value, new_value
	localparam int OUT_TDATA_W = 40;  // data, position, pad

	typedef enum logic [2:0] {
		REQ_PUSH    = 3'd0,
		REQ_POP     = 3'd1,
		REQ_SEARCH  = 3'd2,
		REQ_UPDATE  = 3'd3,
		REQ_DISPLAY = 3'd4
	} req_t;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_FULL     = 2'd1,
		STATUS_EMPTY    = 2'd2,
		STATUS_NOTFOUND = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_POP,
		ST_SCAN,
		ST_DISP
	} state_t;

	// Memory port strobes.
	typedef struct packed {
		logic we;
		logic re;
	} mem_ctl_t;

endpackage

@@ hdl/bss_mem.sv @@
// ----------------------------------------------------------------------------
// bss_mem
// Stack storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bss_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic                      clk,
	input  bss_pkg::mem_ctl_t         ctl,
	input  logic [AW-1:0]             waddr,
	input  logic [bss_pkg::WORD_W-1:0] wdata,
	input  logic [AW-1:0]             raddr,
	output logic [bss_pkg::WORD_W-1:0] rdata
);
	import bss_pkg::*;

	logic [WORD_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds while re is low
	always_ff @(posedge clk) begin
		if (ctl.re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hdl/bounded_stack_with_search_unit.sv @@
// ----------------------------------------------------------------------------
// bounded_stack_with_search_unit
// LIFO stack of signed 32-bit words with push, pop, search, update, display.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_ channel: s_tuser carries the request kind,
//   s_tdata carries value and new_value. Results leave on the m_ channel:
//   m_tuser is the status, m_tdata carries data and position, m_tlast marks
//   the final beat of a request. Every request gives one beat, except
//   display (one beat per entry, top first, at most 16) and the unused kind
//   codes five to seven, which give none.
//   One request is worked on at a time; s_tready is high only in idle.
//   Push answers from its execute state; pop and display first read the top
//   entry; search and update read from the top down to a match or the bottom.
//   Display then gives one beat per cycle while the output register can take
//   it. The scan rate is set by the single read port of the storage memory:
//   one entry per cycle. A result sits in the output register; the next
//   request may be accepted while it waits. With the register full and
//   m_tready low, results and read data hold until it frees; scans go on.
//   Reset empties the stack (fill count to zero) and drops m_tvalid; the
//   memory contents are not cleared and are never read before written.
// ----------------------------------------------------------------------------
module bounded_stack_with_search_unit #(
	parameter int DEPTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// request channel
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [bss_pkg::IN_TDATA_W-1:0]     s_tdata,  // [31:0] value, [63:32] new_value
	input  logic [2:0]                         s_tuser,  // [2:0] req_type
	// result channel
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [bss_pkg::OUT_TDATA_W-1:0]    m_tdata,  // [31:0] data, [36:32] position, pad
	output logic [1:0]                         m_tuser,  // [1:0] status
	output logic                               m_tlast
);
	import bss_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	// control state
	state_t        state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [AW-1:0] ptr_q, ptr_d;     // address of the entry in rdata
	logic [KW-1:0] k_q, k_d;         // display beat index

	// request payload
	req_t              req_q;
	logic [WORD_W-1:0] val_q;
	logic [WORD_W-1:0] nval_q;

	// output register
	logic              m_tvalid_q;
	status_t           out_status_q;
	logic [WORD_W-1:0] out_data_q;
	logic [POS_W-1:0]  out_pos_q;
	logic              out_last_q;

	// memory port
	mem_ctl_t          mem_ctl;
	logic [AW-1:0]     waddr, raddr;
	logic [WORD_W-1:0] wdata, rdata;

	// beat to load into the output register
	logic              emit;
	status_t           e_status;
	logic [WORD_W-1:0] e_data;
	logic [POS_W-1:0]  e_pos;
	logic              e_last;

	logic can_emit;
	logic full, empty, match, disp_last;

	assign can_emit  = !m_tvalid_q || m_tready;
	assign full      = (cnt_q == CW'(DEPTH));
	assign empty     = (cnt_q == '0);
	assign match     = (rdata == val_q);
	assign disp_last = (ptr_q == '0) || (k_q == KW'(MAX_ITEMS - 1));

	bss_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.ctl   (mem_ctl),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Requests are serialized, so a write always lands before the next read
	// is issued: no forwarding path is needed.
	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		ptr_d    = ptr_q;
		k_d      = k_q;
		mem_ctl  = '0;
		waddr    = AW'(cnt_q);
		wdata    = val_q;
		raddr    = AW'(cnt_q - 1'b1);
		emit     = 1'b0;
		e_status = STATUS_OK;
		e_data   = '0;
		e_pos    = '0;
		e_last   = 1'b1;
		s_tready = (state_q == ST_IDLE);

		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				case (req_q)
					REQ_PUSH: begin
						if (can_emit) begin
							emit    = 1'b1;
							state_d = ST_IDLE;
							if (full) begin
								e_status = STATUS_FULL;
							end else begin
								mem_ctl.we = 1'b1;
								cnt_d      = CW'(cnt_q + 1'b1);
							end
						end
					end
					REQ_POP, REQ_SEARCH, REQ_UPDATE, REQ_DISPLAY: begin
						if (empty) begin
							if (can_emit) begin
								emit     = 1'b1;
								e_status = STATUS_EMPTY;
								state_d  = ST_IDLE;
							end
						end else begin
							// fetch the top entry
							mem_ctl.re = 1'b1;
							ptr_d      = AW'(cnt_q - 1'b1);
							k_d        = '0;
							case (req_q)
								REQ_POP:     state_d = ST_POP;
								REQ_DISPLAY: state_d = ST_DISP;
								default:     state_d = ST_SCAN;
							endcase
						end
					end
					default: begin
						// unused kind: no result
						state_d = ST_IDLE;
					end
				endcase
			end
			ST_POP: begin
				if (can_emit) begin
					emit    = 1'b1;
					e_data  = rdata;
					cnt_d   = CW'(cnt_q - 1'b1);
					state_d = ST_IDLE;
				end
			end
			ST_SCAN: begin
				if (match) begin
					if (can_emit) begin
						emit    = 1'b1;
						e_pos   = POS_W'(cnt_q - CW'(ptr_q));
						state_d = ST_IDLE;
						if (req_q == REQ_UPDATE) begin
							mem_ctl.we = 1'b1;
							waddr      = ptr_q;
							wdata      = nval_q;
						end
					end
				end else if (ptr_q == '0) begin
					if (can_emit) begin
						emit     = 1'b1;
						e_status = STATUS_NOTFOUND;
						state_d  = ST_IDLE;
					end
				end else begin
					mem_ctl.re = 1'b1;
					raddr      = AW'(ptr_q - 1'b1);
					ptr_d      = AW'(ptr_q - 1'b1);
				end
			end
			ST_DISP: begin
				if (can_emit) begin
					emit   = 1'b1;
					e_data = rdata;
					e_pos  = POS_W'(k_q) + POS_W'(1);
					e_last = disp_last;
					if (disp_last) begin
						state_d = ST_IDLE;
					end else begin
						mem_ctl.re = 1'b1;
						raddr      = AW'(ptr_q - 1'b1);
						ptr_d      = AW'(ptr_q - 1'b1);
						k_d        = KW'(k_q + 1'b1);
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			ptr_q      <= '0;
			k_q        <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			ptr_q   <= ptr_d;
			k_q     <= k_d;
			if (emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// payload: request latch and output register
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_q  <= req_t'(s_tuser);
			val_q  <= s_tdata[WORD_W-1:0];
			nval_q <= s_tdata[2*WORD_W-1:WORD_W];
		end
		if (emit) begin
			out_status_q <= e_status;
			out_data_q   <= e_data;
			out_pos_q    <= e_pos;
			out_last_q   <= e_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {(OUT_TDATA_W - WORD_W - POS_W)'(0), out_pos_q, out_data_q};
	assign m_tuser  = out_status_q;
	assign m_tlast  = out_last_q;

endmodule

@@ hdl/bss_chk.sv @@
// ----------------------------------------------------------------------------
// bss_chk
// Port-level checks on the stack-with-search block, bound to the top level.
// ----------------------------------------------------------------------------
`include "bounded_stack_with_search_unit_defines.svh"

module bss_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [bss_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic [1:0]                      m_tuser,
	input logic                            m_tlast
);
	import bss_pkg::*;

	logic [OUT_TDATA_W+2:0] m_beat;   // whole result beat
	logic [POS_W-1:0]       m_pos;
	logic                   m_stall, m_err, m_mid;

	assign m_beat  = {m_tlast, m_tuser, m_tdata};
	assign m_pos   = m_tdata[WORD_W +: POS_W];
	assign m_stall = m_tvalid && !m_tready;
	assign m_err   = m_tvalid && (m_tuser != STATUS_OK);
	assign m_mid   = m_tvalid && !m_tlast;

	// stalled result beat holds
	`BSS_ASSERT(a_hold, m_stall |=> m_tvalid && $stable(m_beat), "beat changed while stalled")

	// one request at a time
	`BSS_ASSERT(a_serial, s_tvalid && s_tready |=> !s_tready, "request taken while busy")

	// error beats are single, zero-data beats
	`BSS_ASSERT(a_err, m_err |-> m_tlast && (m_tdata == '0), "bad error beat")

	// only display gives multi-beat results, all ok
	`BSS_ASSERT(a_multi, m_mid |-> (m_tuser == STATUS_OK) && (m_pos != '0), "bad display beat")

	// no result while in reset (output flop is cleared by the first reset edge)
	`BSS_ASSERT_RST(a_rst, !arst_n |=> !m_tvalid, "result valid in reset")

endmodule

bind bounded_stack_with_search_unit bss_chk u_bss_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
